// ===== src/cen_pkg.sv =====
// Shared types and codes for the cell energy image normalizer.
// No dependencies; cen_cfg, cen_div and the top level use it by scoped names.
`timescale 1ns / 1ps

package cen_pkg;

	// request codes
	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_NEW  = 2'd2;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
	localparam logic [1:0] REG_ETA_COUNT  = 2'd1;
	localparam logic [1:0] REG_PHI_COUNT  = 2'd2;

	localparam logic [7:0] IMAGE_SIZE_RST = 8'd77;
	localparam logic [7:0] ETA_COUNT_RST  = 8'd7;
	localparam logic [7:0] PHI_COUNT_RST  = 8'd11;

	// Q2.16 result limits and running sum limits
	localparam logic [17:0] PIX_MAX  = 18'h1FFFF;
	localparam logic [17:0] PIX_MIN  = 18'h20000;
	localparam logic [17:0] PIX_ONE  = 18'h10000;
	localparam logic [17:0] PIX_MONE = 18'h30000;
	localparam logic [27:0] SUM_MAX  = 28'h7FFFFFF;
	localparam logic [27:0] SUM_MIN  = 28'h8000000;

	// divider step counts
	localparam logic [4:0] IDX_STEPS = 5'd7;
	localparam logic [4:0] VAL_STEPS = 5'd18;

	typedef struct packed {
		logic [7:0] image_size;
		logic [7:0] eta_count;
		logic [7:0] phi_count;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [27:0] rem_init;
		logic [17:0] dvd;
		logic [27:0] den;
		logic [4:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [17:0] quo;
		logic [27:0] rem;
	} div_rsp_t;

endpackage

// ===== src/cen_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface cen_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [19:0] cell_energy;
	logic [6:0]         pixel_index;

	modport source (output valid, output req_type, output cell_energy,
		output pixel_index, input ready);
	modport sink (input valid, input req_type, input cell_energy,
		input pixel_index, output ready);
endinterface

interface cen_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] pixel_value;
	logic               out_of_range;

	modport source (output valid, output pixel_value, output out_of_range, input ready);
	modport sink (input valid, input pixel_value, input out_of_range, output ready);
endinterface

// ===== src/cen_cfg.sv =====
// APB register block: image_size, eta_count, phi_count.
// Depends on cen_pkg.
`timescale 1ns / 1ps

module cen_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output cen_pkg::cfg_t cfg
);

	cen_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_size <= cen_pkg::IMAGE_SIZE_RST;
			cfg_q.eta_count  <= cen_pkg::ETA_COUNT_RST;
			cfg_q.phi_count  <= cen_pkg::PHI_COUNT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				cen_pkg::REG_IMAGE_SIZE: cfg_q.image_size <= pwdata[7:0];
				cen_pkg::REG_ETA_COUNT:  cfg_q.eta_count  <= pwdata[7:0];
				cen_pkg::REG_PHI_COUNT:  cfg_q.phi_count  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cen_pkg::REG_IMAGE_SIZE: prdata = {24'd0, cfg_q.image_size};
			cen_pkg::REG_ETA_COUNT:  prdata = {24'd0, cfg_q.eta_count};
			cen_pkg::REG_PHI_COUNT:  prdata = {24'd0, cfg_q.phi_count};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/cen_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Used for the pixel index split and for the energy/sum quotient. Depends on cen_pkg.
`timescale 1ns / 1ps

module cen_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cen_pkg::div_req_t req,
	output cen_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [27:0] rem_q;
	logic [17:0] dvd_q;
	logic [27:0] den_q;
	logic [17:0] quo_q;

	logic [28:0] trial;
	logic [29:0] diff;
	logic        ge;

	assign trial = {rem_q, dvd_q[17]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[29];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dvd;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[27:0] : trial[27:0];
			dvd_q <= {dvd_q[16:0], 1'b0};
			quo_q <= {quo_q[16:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== src/cell_energy_image_normalizer.sv =====
// Top level of the cell energy image normalizer.
// Depends on cen_pkg, cen_if (cen_req_if, cen_rsp_if), cen_cfg and cen_div.
`timescale 1ns / 1ps

// Collects one calorimeter layer's cell energies and serves them back as a
// normalized image. An add beat (req_type 0) folds cell_energy into a
// saturating 28-bit running sum and, while fewer than image_size (and
// MAX_CELLS) cells are held, stores it in the cell memory; add, new-image
// (req_type 2) and unused beats end in ST_IDLE and give no result. A read
// beat (req_type 1) maps pixel p to eta = p mod eta_count, phi = p div
// eta_count, fetches source cell phi + phi_count*eta and returns it divided
// by the running sum as saturated, round-half-away Q2.16 (raw energy in Q2.16
// when the sum is zero, zero for padded cells, out_of_range when p is not
// below image_size). A full read runs the one shared restoring divider for
// the index split in ST_IDX, reads the cell memory in ST_SRC and ST_MEM,
// then runs it again for the quotient in ST_PREP and ST_DIV before ST_RES.
// Out-of-range and zero eta_count reads go straight to ST_RES; padded,
// zero-sum and saturating reads leave the sequence early. Reads
// are handled one at a time; a finished result sits in an output register,
// so the next request is accepted while it waits. The cell memory needs no
// clearing after reset: only cells written for the current image are read.
module cell_energy_image_normalizer #(
	parameter int MAX_CELLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	cen_req_if.sink     req,
	cen_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_CELLS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_IDX  = 3'd1;
	localparam logic [2:0] ST_SRC  = 3'd2;
	localparam logic [2:0] ST_MEM  = 3'd3;
	localparam logic [2:0] ST_PREP = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_RES  = 3'd6;

	cen_pkg::cfg_t     cfg;
	cen_pkg::div_req_t dreq;
	cen_pkg::div_rsp_t drsp;

	logic [2:0]  state_q;
	logic [27:0] sum_q;
	logic [7:0]  seen_q;

	logic signed [19:0] mem [MAX_CELLS];
	logic [19:0] rd_q;

	logic [16:0] src_q;
	logic [19:0] abs_val_q;
	logic [27:0] abs_sum_q;
	logic        neg_q;
	logic [17:0] res_val_q;
	logic        res_oor_q;
	logic [17:0] out_val_q;
	logic        out_oor_q;
	logic        out_vld_q;

	logic        acc;
	logic        in_range;
	logic        can_store;
	logic [28:0] sum_ext;
	logic [27:0] sum_sat;
	logic [16:0] src_calc;
	logic [19:0] abs_val;
	logic [27:0] abs_sum;
	logic [35:0] num_rnd;
	logic        q_ovf;
	logic [17:0] zero_sum_val;
	logic [17:0] q_val;
	logic        slot_free;

	cen_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cen_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid & req.ready;
	assign in_range  = ({1'b0, req.pixel_index} < cfg.image_size);
	assign can_store = (seen_q < cfg.image_size) && (32'(seen_q) < MAX_CELLS);

	// saturating running sum
	assign sum_ext = {sum_q[27], sum_q} + {{9{req.cell_energy[19]}}, req.cell_energy};
	always_comb begin
		if (sum_ext[28] != sum_ext[27]) begin
			sum_sat = sum_ext[28] ? cen_pkg::SUM_MIN : cen_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_ext[27:0];
		end
	end

	// source index: quotient is phi, remainder is eta; phi_count*eta needs 16 bits
	assign src_calc = 17'(drsp.quo[6:0]) +
		{1'b0, {8'd0, cfg.phi_count} * {8'd0, drsp.rem[7:0]}};

	assign abs_val = rd_q[19] ? (~rd_q + 20'd1) : rd_q;
	assign abs_sum = sum_q[27] ? (~sum_q + 28'd1) : sum_q;

	// numerator with half the divisor added for round-half-away
	assign num_rnd = {abs_val_q, 16'd0} + {9'd0, abs_sum_q[27:1]};
	assign q_ovf   = ({10'd0, num_rnd[35:18]} >= abs_sum_q);

	// zero sum: raw energy times 2^16, saturated
	always_comb begin
		priority if (rd_q == 20'd0) begin
			zero_sum_val = 18'd0;
		end else if (rd_q == 20'd1) begin
			zero_sum_val = cen_pkg::PIX_ONE;
		end else if (rd_q == 20'hFFFFF) begin
			zero_sum_val = cen_pkg::PIX_MONE;
		end else if (rd_q[19]) begin
			zero_sum_val = cen_pkg::PIX_MIN;
		end else begin
			zero_sum_val = cen_pkg::PIX_MAX;
		end
	end

	// signed, clamped quotient
	always_comb begin
		if (neg_q) begin
			q_val = drsp.quo[17] ? cen_pkg::PIX_MIN : (~drsp.quo + 18'd1);
		end else begin
			q_val = (drsp.quo >= cen_pkg::PIX_MAX) ? cen_pkg::PIX_MAX : drsp.quo;
		end
	end

	// divider launch: index split on accept, quotient from ST_PREP
	always_comb begin
		dreq = '0;
		if (acc && req.req_type == cen_pkg::REQ_READ && in_range && cfg.eta_count != 8'd0) begin
			dreq.start = 1'b1;
			dreq.dvd   = {req.pixel_index, 11'd0};
			dreq.den   = {20'd0, cfg.eta_count};
			dreq.steps = cen_pkg::IDX_STEPS;
		end else if (state_q == ST_PREP && !q_ovf) begin
			dreq.start    = 1'b1;
			dreq.rem_init = {10'd0, num_rnd[35:18]};
			dreq.dvd      = num_rnd[17:0];
			dreq.den      = abs_sum_q;
			dreq.steps    = cen_pkg::VAL_STEPS;
		end
	end

	assign slot_free = ~out_vld_q | rsp.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			seen_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.req_type)
							cen_pkg::REQ_ADD: begin
								sum_q <= sum_sat;
								if (can_store) begin
									seen_q <= seen_q + 8'd1;
								end
							end
							cen_pkg::REQ_NEW: begin
								sum_q  <= '0;
								seen_q <= '0;
							end
							cen_pkg::REQ_READ: begin
								if (in_range && cfg.eta_count != 8'd0) begin
									state_q <= ST_IDX;
								end else begin
									state_q <= ST_RES;
								end
							end
							default: ;
						endcase
					end
				end
				ST_IDX: if (drsp.done) begin
					state_q <= ST_SRC;
				end
				ST_SRC: state_q <= (src_q < {9'd0, seen_q}) ? ST_MEM : ST_RES;
				ST_MEM: state_q <= (sum_q == 28'd0) ? ST_RES : ST_PREP;
				ST_PREP: state_q <= q_ovf ? ST_RES : ST_DIV;
				ST_DIV: if (drsp.done) begin
					state_q <= ST_RES;
				end
				ST_RES: if (slot_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_val_q <= 18'd0;
				res_oor_q <= ~in_range;
			end
			ST_IDX: src_q <= src_calc;
			ST_MEM: begin
				abs_val_q <= abs_val;
				abs_sum_q <= abs_sum;
				neg_q     <= rd_q[19] ^ sum_q[27];
				res_val_q <= zero_sum_val;
			end
			ST_PREP: res_val_q <= neg_q ? cen_pkg::PIX_MIN : cen_pkg::PIX_MAX;
			ST_DIV: res_val_q <= q_val;
			default: ;
		endcase
	end

	// cell memory: write on stored adds, registered read
	always_ff @(posedge clk) begin
		if (acc && req.req_type == cen_pkg::REQ_ADD && can_store) begin
			mem[AW'(seen_q)] <= req.cell_energy;
		end
		if (state_q == ST_SRC) begin
			rd_q <= mem[AW'(src_q)];
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RES && slot_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RES && slot_free) begin
			out_val_q <= res_val_q;
			out_oor_q <= res_oor_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.pixel_value  = out_val_q;
	assign rsp.out_of_range = out_oor_q;

endmodule
